@@ hdl/bsed_pkg.sv @@
// ----------------------------------------------------------------------------
// bsed_pkg
// Types and fixed constants of the brightness slope edge detector.
// ----------------------------------------------------------------------------
package bsed_pkg;

  // field widths fixed by the interface
  localparam int BRIGHT_W = 7;
  localparam int DIST_W   = 32;
  localparam int RATE_W   = 16;

  // distance difference, exact at one bit more than the distance
  localparam int DD_W = DIST_W + 1;

  // low part of the distance difference fed to the multiplier; a larger
  // difference can never pass with a nonzero rate since |db| * 256 < 2^15
  localparam int DD_LO_W = 17;

  // product of rate and the low part of the difference
  localparam int PROD_W = RATE_W + DD_LO_W;

  // reset value of the rate register, 1.0 in Q8.8
  localparam logic [RATE_W-1:0] RATE_RESET = 16'd256;

  // an entry counts only if the distance grew by more than this
  localparam int MIN_DISTANCE_STEP = 3;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DRAIN,
    S_OUT
  } state_t;

endpackage

@@ hdl/brightness_slope_edge_detector.sv @@
// ----------------------------------------------------------------------------
// brightness_slope_edge_detector
// Keeps a history of brightness and distance samples and flags a sample whose
// brightness slope against some older entry reaches the configured rate.
// ----------------------------------------------------------------------------
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------
//   in      | input     | in_valid/in_ready  | brightness, travelled
//   out     | output    | out_valid/out_ready| detected
//   cfg     | input     | cfg_we             | cfg_wdata (min_change_rate)
//
// the result beat follows the walk over the older valid entries, at most
// HISTORY_DEPTH - 1, and the drain of the pipe; no new sample is taken until
// the result beat is taken. one entry a cycle goes from the history RAM
// through a subtract, multiply, compare pipe. in_ready is high only while
// idle and the result beat is held until taken. reset clears the fill count
// and pointers, sets the rate to 1.0; RAM words past the fill count are unused.
module brightness_slope_edge_detector
  import bsed_pkg::*;
#(
  parameter int HISTORY_DEPTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [BRIGHT_W-1:0] brightness,
  input  logic [DIST_W-1:0]   travelled,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                detected,
  input  logic                cfg_we,
  input  logic [RATE_W-1:0]   cfg_wdata
);

  localparam int PTR_W = $clog2(HISTORY_DEPTH);
  localparam int CNT_W = $clog2(HISTORY_DEPTH + 1);
  localparam int ENT_W = BRIGHT_W + DIST_W;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(HISTORY_DEPTH - 1);
  localparam logic [CNT_W-1:0] FILL_MAX = CNT_W'(HISTORY_DEPTH);

  state_t state, state_next;

  logic [RATE_W-1:0]   rate;
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    fill;
  logic [CNT_W-1:0]    fill_next;
  logic [CNT_W-1:0]    left;
  logic [BRIGHT_W-1:0] newest_bright;
  logic [DIST_W-1:0]   newest_dist;
  logic                hit_acc;

  logic                in_beat;
  logic                out_beat;
  logic                issue;
  logic                pipe_busy;

  logic [ENT_W-1:0]    ram_rdata;
  logic [BRIGHT_W-1:0] rd_bright;
  logic [DIST_W-1:0]   rd_dist;

  // pipe stage registers
  logic                v1;
  logic                v2;
  logic                use2;
  logic                big2;
  logic [BRIGHT_W-1:0] db2;
  logic [DD_LO_W-1:0]  dd_lo2;
  logic                v3;
  logic                use3;
  logic                big3;
  logic [BRIGHT_W-1:0] db3;
  logic [PROD_W-1:0]   prod3;

  logic [DD_W-1:0]     dd;
  logic                far;
  logic [BRIGHT_W-1:0] db;
  logic [PROD_W-1:0]   prod;
  logic [PROD_W-1:0]   lhs;
  logic                pass;

  assign in_beat   = in_valid && in_ready;
  assign out_beat  = out_valid && out_ready;
  assign pipe_busy = v1 || v2 || v3;

  // fill count after taking the current sample
  assign fill_next = (fill == FILL_MAX) ? fill : fill + CNT_W'(1);

  // history RAM, one entry holds brightness and distance
  bsed_ram #(
    .WIDTH (ENT_W),
    .DEPTH (HISTORY_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (in_beat),
    .waddr (wr_ptr),
    .wdata ({brightness, travelled}),
    .raddr (rd_ptr),
    .rdata (ram_rdata)
  );

  assign rd_bright = ram_rdata[ENT_W-1:DIST_W];
  assign rd_dist   = ram_rdata[DIST_W-1:0];

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          state_next = (fill_next > CNT_W'(1)) ? S_WALK : S_DRAIN;
        end
      end
      S_WALK: begin
        if (left == CNT_W'(1)) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!pipe_busy) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    issue     = 1'b0;
    unique case (state)
      S_IDLE:  in_ready  = 1'b1;
      S_WALK:  issue     = 1'b1;
      S_DRAIN: ;
      S_OUT:   out_valid = 1'b1;
      default: ;
    endcase
  end

  assign detected = hit_acc;

  // state, rate register and history pointers
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      rate   <= RATE_RESET;
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
      left   <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        rate <= cfg_wdata;
      end
      if (in_beat) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
        rd_ptr <= (wr_ptr == '0) ? PTR_LAST : wr_ptr - PTR_W'(1);
        fill   <= fill_next;
        left   <= fill_next - CNT_W'(1);
      end else if (issue) begin
        rd_ptr <= (rd_ptr == '0) ? PTR_LAST : rd_ptr - PTR_W'(1);
        left   <= left - CNT_W'(1);
      end
    end
  end

  // newest sample kept aside for the walk
  always_ff @(posedge clk) begin
    if (in_beat) begin
      newest_bright <= brightness;
      newest_dist   <= travelled;
    end
  end

  // stage 2 logic: distance and brightness differences
  always_comb begin
    dd  = {newest_dist[DIST_W-1], newest_dist} - {rd_dist[DIST_W-1], rd_dist};
    far = !dd[DD_W-1] && (dd > DD_W'(MIN_DISTANCE_STEP));
    db  = (newest_bright >= rd_bright) ? newest_bright - rd_bright
                                       : rd_bright - newest_bright;
  end

  // stage 3 logic: rate times distance difference
  assign prod = PROD_W'(rate) * PROD_W'(dd_lo2);

  // stage 4 logic: exact slope compare
  assign lhs  = PROD_W'({db3, 8'h00});
  assign pass = use3 && (big3 ? (rate == '0) : (lhs >= prod3));

  // pipe valid bits and the detection flag
  always_ff @(posedge clk) begin
    if (rst) begin
      v1      <= 1'b0;
      v2      <= 1'b0;
      v3      <= 1'b0;
      hit_acc <= 1'b0;
    end else begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
      if (in_beat) begin
        hit_acc <= 1'b0;
      end else if (v3 && pass) begin
        hit_acc <= 1'b1;
      end
    end
  end

  // pipe payload registers
  always_ff @(posedge clk) begin
    use2   <= far;
    big2   <= |dd[DD_W-2:DD_LO_W];
    db2    <= db;
    dd_lo2 <= dd[DD_LO_W-1:0];
    use3   <= use2;
    big3   <= big2;
    db3    <= db2;
    prod3  <= prod;
  end

endmodule

@@ hdl/bsed_ram.sv @@
// ----------------------------------------------------------------------------
// bsed_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bsed_ram #(
  parameter int WIDTH = 39,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ tb/brightness_slope_edge_detector_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// brightness_slope_edge_detector_tb
// Drives samples through the slope edge detector under random idling on both
// channels and checks every detect flag against a cycle-free predictor that
// keeps its own copy of the brightness and distance history and of the rate.
// ----------------------------------------------------------------------------
module brightness_slope_edge_detector_tb
  import bsed_pkg::*;
();

  localparam int HIST_DEPTH     = 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int SETTLE_CYCLES  = 30;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_PHASES       = 7;
  localparam int PHASE_ITEMS    = 105;
  localparam int N_DIRECTED     = 20;

  // predictor of the detect flag plus the queue of flags still owed
  class slope_scoreboard;
    logic [RATE_W-1:0]   rate;
    logic [BRIGHT_W-1:0] light_hist [HIST_DEPTH];
    logic [DIST_W-1:0]   dist_hist [HIST_DEPTH];
    int                  fill;
    logic                detect_q [$];
    int                  errors;

    function new();
      rate   = RATE_RESET;
      fill   = 0;
      errors = 0;
      foreach (light_hist[i]) begin
        light_hist[i] = '0;
        dist_hist[i]  = '0;
      end
    endfunction

    task report(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    // push the sample into the history and work out its detect flag
    function void note_sample(input logic [BRIGHT_W-1:0] b, input logic [DIST_W-1:0] t);
      int                k;
      logic              hit;
      longint            dd;
      longint unsigned   db;
      longint unsigned   lhs;
      longint unsigned   rhs;
      hit = 1'b0;
      if (fill < HIST_DEPTH) fill++;
      for (k = HIST_DEPTH - 1; k > 0; k--) begin
        light_hist[k] = light_hist[k-1];
        dist_hist[k]  = dist_hist[k-1];
      end
      light_hist[0] = b;
      dist_hist[0]  = t;
      // newest first, stop at the first entry that reaches the rate
      for (k = 1; k < fill && !hit; k++) begin
        dd = longint'($signed(dist_hist[0])) - longint'($signed(dist_hist[k]));
        if (dd > MIN_DISTANCE_STEP) begin
          if (light_hist[0] >= light_hist[k]) db = light_hist[0] - light_hist[k];
          else db = light_hist[k] - light_hist[0];
          lhs = db << 8;
          rhs = longint'(rate) * longint'(dd);
          if (lhs >= rhs) hit = 1'b1;
        end
      end
      detect_q.push_back(hit);
    endfunction

    task check_detect(input logic got);
      logic want;
      if (detect_q.size() == 0) begin
        report($sformatf("result beat detected=%b with no sample waiting", got));
      end else begin
        want = detect_q.pop_front();
        if (got !== want)
          report($sformatf("detected=%b, predicted %b", got, want));
      end
    endtask

    function int pending();
      return detect_q.size();
    endfunction

    task check_drained();
      if (detect_q.size() != 0)
        report($sformatf("%0d detect flags never arrived", detect_q.size()));
    endtask
  endclass

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  logic [BRIGHT_W-1:0] brightness = '0;
  logic [DIST_W-1:0]   travelled  = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic                detected;
  logic                cfg_we    = 1'b0;
  logic [RATE_W-1:0]   cfg_wdata = '0;

  slope_scoreboard sb;
  bit              rx_hold_req = 1'b0;
  int              tx_steady_left = 0;
  int              stall_cycles = 0;

  brightness_slope_edge_detector #(
    .HISTORY_DEPTH(HIST_DEPTH)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .brightness(brightness),
    .travelled (travelled),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .detected  (detected),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always #5 clk = ~clk;

  // watchdog: too long with no beat on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // offer one sample after a random gap, hold it until taken
  task automatic send_sample(input logic [BRIGHT_W-1:0] b, input logic [DIST_W-1:0] t);
    int gap;
    if (tx_steady_left > 0) begin
      tx_steady_left--;
      gap = 0;
    end else begin
      gap = $urandom_range(0, 5);
      if ($urandom_range(0, 29) == 0) tx_steady_left = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    brightness <= b;
    travelled  <= t;
    do @(posedge clk); while (!(in_valid && in_ready));
    sb.note_sample(b, t);
  endtask

  // wait for every owed flag, then let the block go idle
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_rate(input logic [RATE_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.rate = v;
  endtask

  // result side: random ready gaps, steady stretches, one long hold on request
  initial begin : result_sink
    int wait_n;
    int steady_left;
    bit hold_done;
    steady_left = 0;
    hold_done   = 1'b0;
    wait (!rst);
    forever begin
      if (rx_hold_req && !hold_done) begin
        hold_done = 1'b1;
        wait_n    = HOLD_CYCLES;
      end else if (steady_left > 0) begin
        steady_left--;
        wait_n = 0;
      end else begin
        wait_n = $urandom_range(0, 5);
        if ($urandom_range(0, 29) == 0) steady_left = $urandom_range(10, 40);
      end
      if (wait_n > 0) begin
        out_ready <= 1'b0;
        repeat (wait_n) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      sb.check_detect(detected);
    end
  end

  // directed samples: first sample, skipped small steps, exact equality,
  // distance wrap both ways, brightness above 100, history saturation
  logic [BRIGHT_W-1:0] dir_bright [N_DIRECTED] = '{
    7'd0, 7'd100, 7'd0, 7'd127, 7'd127, 7'd0, 7'd127, 7'd127, 7'd64, 7'd65,
    7'd69, 7'd72, 7'd73, 7'd0, 7'd100, 7'd0, 7'd100, 7'd50, 7'd101, 7'd1
  };
  logic [DIST_W-1:0] dir_dist [N_DIRECTED] = '{
    32'd0, 32'd2, 32'd4, 32'd8, 32'd8, 32'h7FFF_FFFF, 32'h8000_0000,
    32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'd3, 32'd7, 32'd10, 32'd14, 32'd15,
    32'd16, 32'd17, 32'd18, 32'd19, 32'd20, 32'd21
  };

  initial begin : stimulus
    logic [RATE_W-1:0] phase_rate [N_PHASES];
    logic [DIST_W-1:0] odo;
    int                level;
    int                kind;
    sb = new();
    phase_rate[0] = '0;
    phase_rate[1] = '1;
    phase_rate[2] = RATE_RESET;
    phase_rate[3] = RATE_W'($urandom_range(2, 3000));
    phase_rate[4] = 16'd1;
    phase_rate[5] = RATE_W'($urandom_range(2, 3000));
    phase_rate[6] = RATE_W'($urandom_range(2, 7000));
    odo   = 32'd21;
    level = 50;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed part at the reset rate
    for (int i = 0; i < N_DIRECTED; i++) send_sample(dir_bright[i], dir_dist[i]);
    settle();

    for (int p = 0; p < N_PHASES; p++) begin
      write_rate(phase_rate[p]);
      // receiver stalls long while samples keep coming
      if (p == 2) rx_hold_req = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        kind = $urandom_range(0, 9);
        if (kind < 8) begin
          // forward drift with brightness wandering around the last level
          odo = odo + $urandom_range(0, 8);
          if ($urandom_range(0, 3) == 0) begin
            level = $urandom_range(0, 100);
          end else begin
            level = level + int'($urandom_range(0, 40)) - 20;
            if (level < 0) level = 0;
            if (level > 100) level = 100;
          end
        end else if (kind == 8) begin
          odo   = $urandom;
          level = $urandom_range(0, 127);
        end else begin
          odo   = odo - $urandom_range(0, 16);
          level = $urandom_range(0, 127);
        end
        send_sample(level[BRIGHT_W-1:0], odo);
      end
      settle();
    end

    sb.check_drained();
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

@@ sim.f @@
hdl/bsed_pkg.sv
hdl/bsed_ram.sv
hdl/brightness_slope_edge_detector.sv
tb/brightness_slope_edge_detector_tb.sv
